// File: design/epmd_pkg.sv
`default_nettype none

package epmd_pkg;

   // field and register widths
   localparam int TARGET_W = 17;
   localparam int SCALE_W  = 16;
   localparam int GAIN_W   = 24;
   localparam int LEVEL_W  = 8;
   localparam int DUTY_W   = 9;
   localparam int COUNT_W  = 16;
   localparam int TIME_W   = 32;
   localparam int WINDOW_W = 16;
   localparam int SPEED_W  = 24;  // count * scale >> 8
   localparam int ERR_W    = 26;  // holds target - speed over the full ranges
   localparam int CHUNK_W  = 16;  // operand digit fed to the multiplier per step
   localparam int FRAC_W   = 32;  // Q8 * Q24 products

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_VELOCITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_SCALE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_P_GAIN          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_I_GAIN          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_MS       = 3'd5;

   localparam logic MODE_PULSE   = 1'b0;
   localparam logic MODE_CONTROL = 1'b1;

   typedef enum logic [2:0] {
      STEP_SPEED = 3'd0,
      STEP_INTEG = 3'd1,
      STEP_MUL_I = 3'd2,
      STEP_MUL_P = 3'd3,
      STEP_ABS   = 3'd4,
      STEP_CLAMP = 3'd5
   } step_type;

   typedef enum logic [1:0] {
      MUL_NONE  = 2'd0,
      MUL_SPEED = 2'd1,
      MUL_INT   = 2'd2,
      MUL_ERR   = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD  = 2'd0,
      ACC_CLR   = 2'd1,
      ACC_SHADD = 2'd2,
      ACC_ADD   = 2'd3
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT = 2'd0,
      JMP_LOOP = 2'd1,
      JMP_END  = 2'd2
   } jmp_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        err_we;
      logic        int_we;
      logic        abs_we;
      logic        out_we;
      jmp_type     jmp;
      step_type    nxt;
      step_type    alt;
   } ucode_type;

   typedef struct packed {
      logic loop_done;
   } status_type;

   localparam ucode_type UC_NOP = '{MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                    JMP_NEXT, STEP_SPEED, STEP_SPEED};

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      w = UC_NOP;
      case (s)
         STEP_SPEED: begin
            w.mul_sel = MUL_SPEED;
            w.err_we  = 1'b1;
            w.nxt     = STEP_INTEG;
         end
         STEP_INTEG: begin
            w.acc_op = ACC_CLR;
            w.int_we = 1'b1;
            w.nxt    = STEP_MUL_I;
         end
         STEP_MUL_I: begin
            w.mul_sel = MUL_INT;
            w.acc_op  = ACC_SHADD;
            w.nxt     = STEP_MUL_P;
         end
         STEP_MUL_P: begin
            w.mul_sel = MUL_ERR;
            w.acc_op  = ACC_ADD;
            w.jmp     = JMP_LOOP;
            w.nxt     = STEP_ABS;
            w.alt     = STEP_MUL_I;
         end
         STEP_ABS: begin
            w.abs_we = 1'b1;
            w.nxt    = STEP_CLAMP;
         end
         STEP_CLAMP: begin
            w.out_we = 1'b1;
            w.jmp    = JMP_END;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: design/epmd_datapath.sv
`default_nettype none

module epmd_datapath import epmd_pkg::*; #(
   parameter int INTEGRATOR_BITS = 40
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ucode_type                   ctl,
   input  wire logic signed [TARGET_W-1:0]  target_velocity,
   input  wire logic [SCALE_W-1:0]          vel_scale,
   input  wire logic [GAIN_W-1:0]           p_gain,
   input  wire logic [GAIN_W-1:0]           i_gain,
   input  wire logic [LEVEL_W-1:0]          drive_offset,
   input  wire logic [COUNT_W-1:0]          measured_count,
   output status_type                       status,
   output logic [LEVEL_W-1:0]               forward_level,
   output logic [LEVEL_W-1:0]               reverse_level,
   output logic signed [DUTY_W-1:0]         duty_value
);

   localparam int IB     = INTEGRATOR_BITS;
   localparam int OP_MAX = (IB > ERR_W) ? IB : ERR_W;
   localparam int SUM_W  = OP_MAX + 1;
   localparam int NC     = (OP_MAX + CHUNK_W - 1) / CHUNK_W;
   localparam int OPW    = NC * CHUNK_W;
   localparam int ACC_W  = OPW + GAIN_W + 1;
   localparam int CW     = (NC > 1) ? $clog2(NC) : 1;
   localparam int PROD_W = CHUNK_W + GAIN_W + 2;
   localparam int QH_W   = ACC_W - FRAC_W;

   localparam logic signed [SUM_W-1:0] IMAX = {{(SUM_W-IB+1){1'b0}}, {(IB-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] IMIN = ~IMAX;
   localparam logic [CW-1:0]           CNT_TOP = CW'(NC - 1);

   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [IB-1:0]    int_ff, int_in;
   logic [OPW-1:0]          xop_ff, xop_in;
   logic [OPW-1:0]          eop_ff, eop_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;

   logic signed [CHUNK_W:0] mul_a;
   logic signed [GAIN_W:0]  mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [SPEED_W-1:0]      speed;
   logic signed [SUM_W-1:0] int_sum, int_sat;
   logic [CHUNK_W-1:0]      x_top, e_top;
   logic                    top_flag;

   // digits go most significant first; only the top digit carries the sign
   assign x_top    = xop_ff[OPW-1 -: CHUNK_W];
   assign e_top    = eop_ff[OPW-1 -: CHUNK_W];
   assign top_flag = (cnt_ff == CNT_TOP);

   always_comb begin
      case (ctl.mul_sel)
         MUL_SPEED: begin
            mul_a = $signed({1'b0, measured_count});
            mul_b = $signed({1'b0, GAIN_W'(vel_scale)});
         end
         MUL_INT: begin
            mul_a = $signed({top_flag & x_top[CHUNK_W-1], x_top});
            mul_b = $signed({1'b0, i_gain});
         end
         MUL_ERR: begin
            mul_a = $signed({top_flag & e_top[CHUNK_W-1], e_top});
            mul_b = $signed({1'b0, p_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign speed = prod[SPEED_W+7:8];

   // saturating integrator
   assign int_sum = SUM_W'(int_ff) + SUM_W'(err_ff);
   always_comb begin
      if (int_sum > IMAX) begin
         int_sat = IMAX;
      end else if (int_sum < IMIN) begin
         int_sat = IMIN;
      end else begin
         int_sat = int_sum;
      end
   end

   always_comb begin
      err_in = err_ff;
      int_in = int_ff;
      xop_in = xop_ff;
      eop_in = eop_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      if (ctl.err_we) begin
         err_in = ERR_W'(target_velocity) - $signed({2'b00, speed});
      end
      if (ctl.int_we) begin
         int_in = $signed(int_sat[IB-1:0]);
         xop_in = OPW'(int_in);
         eop_in = OPW'(err_ff);
         cnt_in = CNT_TOP;
      end
      if (ctl.mul_sel == MUL_INT) begin
         xop_in = xop_ff << CHUNK_W;
      end
      if (ctl.mul_sel == MUL_ERR) begin
         eop_in = eop_ff << CHUNK_W;
         cnt_in = cnt_ff - CW'(1);
      end
      case (ctl.acc_op)
         ACC_CLR:   acc_in = '0;
         ACC_SHADD: acc_in = (acc_ff <<< CHUNK_W) + ACC_W'(prod);
         ACC_ADD:   acc_in = acc_ff + ACC_W'(prod);
         default:   acc_in = acc_ff;
      endcase
      if (ctl.abs_we) begin
         neg_in = acc_ff[ACC_W-1];
         mag_in = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff <= '0;
      end else begin
         int_ff <= int_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      xop_ff <= xop_in;
      eop_ff <= eop_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   assign status.loop_done = (cnt_ff == '0);

   // clamp of the magnitude, truncated toward zero
   logic [QH_W-1:0]    q_hi;
   logic [LEVEL_W-1:0] lim, q;
   logic               big;

   assign q_hi = mag_ff[ACC_W-1:FRAC_W];
   assign lim  = ~drive_offset;
   assign big  = |q_hi[QH_W-1:LEVEL_W];
   assign q    = (big || (q_hi[LEVEL_W-1:0] > lim)) ? lim : q_hi[LEVEL_W-1:0];

   always_comb begin
      forward_level = '0;
      reverse_level = '0;
      duty_value    = '0;
      if (q != '0) begin
         if (neg_ff) begin
            reverse_level = q + drive_offset;
            duty_value    = -$signed({1'b0, q});
         end else begin
            forward_level = q + drive_offset;
            duty_value    = $signed({1'b0, q});
         end
      end
   end

endmodule

`default_nettype wire

// File: design/encoder_pi_motor_drive_core.sv
// Pulse request: no response, accepted whenever no control update runs.
// Control request: the microprogram runs a multiply loop of two steps per operand digit over
// ceil(max(INTEGRATOR_BITS,26)/16) digits before the response is loaded.
// One control request at a time: the next is taken the cycle after the response is loaded.
// Synchronous active-high reset: CSRs take their defaults, counters and integrator clear.
`default_nettype none

module encoder_pi_motor_drive_core import epmd_pkg::*; #(
   parameter int INTEGRATOR_BITS = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,   // [31:0] time_ms
   input  wire logic                   req_tuser,   // [0] mode
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [7:0] forward_level, [15:8] reverse_level,
                                                    // [24:16] duty_value, [31:25] zero
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [TARGET_W-1:0] target_ff, target_in;
   logic [SCALE_W-1:0]         scale_ff, scale_in;
   logic [GAIN_W-1:0]          p_gain_ff, p_gain_in;
   logic [GAIN_W-1:0]          i_gain_ff, i_gain_in;
   logic [LEVEL_W-1:0]         offset_ff, offset_in;
   logic [WINDOW_W-1:0]        window_ff, window_in;
   logic                       csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      target_in = target_ff;
      scale_in  = scale_ff;
      p_gain_in = p_gain_ff;
      i_gain_in = i_gain_ff;
      offset_in = offset_ff;
      window_in = window_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_TARGET_VELOCITY: target_in = $signed(csr_data[TARGET_W-1:0]);
            REG_VEL_SCALE:       scale_in  = csr_data[SCALE_W-1:0];
            REG_P_GAIN:          p_gain_in = csr_data[GAIN_W-1:0];
            REG_I_GAIN:          i_gain_in = csr_data[GAIN_W-1:0];
            REG_DRIVE_OFFSET:    offset_in = csr_data[LEVEL_W-1:0];
            REG_WINDOW_MS:       window_in = csr_data[WINDOW_W-1:0];
            default:             ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_W'(3840);
         scale_ff  <= SCALE_W'(31576);
         p_gain_ff <= GAIN_W'(67109);
         i_gain_ff <= GAIN_W'(503);
         offset_ff <= LEVEL_W'(40);
         window_ff <= WINDOW_W'(100);
      end else begin
         target_ff <= target_in;
         scale_ff  <= scale_in;
         p_gain_ff <= p_gain_in;
         i_gain_ff <= i_gain_in;
         offset_ff <= offset_in;
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic busy_ff, busy_in;
   logic req_acc, pulse_acc, ctl_acc;

   assign req_tready = ~busy_ff;
   assign req_acc    = req_tvalid & req_tready;
   assign pulse_acc  = req_acc & (req_tuser == MODE_PULSE);
   assign ctl_acc    = req_acc & (req_tuser == MODE_CONTROL);

   // ---------------------------------------------------------------
   // Pulse counter and window latch
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0] pulse_ff, pulse_in, pulse_inc;
   logic [COUNT_W-1:0] meas_ff, meas_in;
   logic [TIME_W-1:0]  latch_ff, latch_in, elapsed;

   // counter sticks at full scale
   assign pulse_inc = (&pulse_ff) ? pulse_ff : pulse_ff + COUNT_W'(1);
   // wrap-safe elapsed time
   assign elapsed   = req_tdata - latch_ff;

   always_comb begin
      pulse_in = pulse_ff;
      meas_in  = meas_ff;
      latch_in = latch_ff;
      if (pulse_acc) begin
         if (elapsed > TIME_W'(window_ff)) begin
            latch_in = req_tdata;
            meas_in  = pulse_inc;  // this pulse counts in the closing window
            pulse_in = '0;
         end else begin
            pulse_in = pulse_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= '0;
         meas_ff  <= '0;
         latch_ff <= '0;
      end else begin
         pulse_ff <= pulse_in;
         meas_ff  <= meas_in;
         latch_ff <= latch_in;
      end
   end

   // ---------------------------------------------------------------
   // Microprogram sequencer
   //   SPEED -> INTEG -> (MUL_I, MUL_P) per operand digit -> ABS -> CLAMP
   //   CLAMP holds until the response register is free.
   // ---------------------------------------------------------------
   step_type   step_ff, step_in;
   ucode_type  uc;
   status_type dp_status;
   logic       out_free;

   assign uc = busy_ff ? ucode_rom(step_ff) : UC_NOP;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (ctl_acc) begin
            busy_in = 1'b1;
            step_in = STEP_SPEED;
         end
      end else begin
         case (uc.jmp)
            JMP_NEXT: step_in = uc.nxt;
            JMP_LOOP: step_in = dp_status.loop_done ? uc.nxt : uc.alt;
            JMP_END: begin
               if (out_free) begin
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_SPEED;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0]       fwd_lvl, rev_lvl;
   logic signed [DUTY_W-1:0] duty;

   epmd_datapath #(
      .INTEGRATOR_BITS (INTEGRATOR_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (uc),
      .target_velocity (target_ff),
      .vel_scale       (scale_ff),
      .p_gain          (p_gain_ff),
      .i_gain          (i_gain_ff),
      .drive_offset    (offset_ff),
      .measured_count  (meas_ff),
      .status          (dp_status),
      .forward_level   (fwd_lvl),
      .reverse_level   (rev_lvl),
      .duty_value      (duty)
   );

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_load;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign rsp_load = uc.out_we & out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, duty, rev_lvl, fwd_lvl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_ctl_starts: assert property (@(posedge clock) disable iff (reset)
      ctl_acc |=> busy_ff && (step_ff == STEP_SPEED))
      else $error("control request did not start the microprogram");

   a_pulse_no_run: assert property (@(posedge clock) disable iff (reset)
      pulse_acc |=> !busy_ff)
      else $error("pulse request started the microprogram");

   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff == STEP_MUL_P) && dp_status.loop_done |=> step_ff == STEP_ABS)
      else $error("multiply loop did not exit to ABS");

   a_one_bridge_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0) || (rsp_tdata[15:8] == 8'd0))
      else $error("both bridge levels driven");

   a_load_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> busy_ff && (step_ff == STEP_CLAMP))
      else $error("response loaded outside the clamp step");

endmodule

`default_nettype wire
